// ===== hdl/xml_entity_decoder_core_assert.svh =====
// Assertion macros for the XML entity decoder checker.
// Included by the checker file; depends on nothing else.
`ifndef XML_ENTITY_DECODER_CORE_ASSERT_SVH
`define XML_ENTITY_DECODER_CORE_ASSERT_SVH

// Expression must hold at every clock edge outside reset.
`define XED_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define XED_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/xed_pkg.sv =====
// Shared types, character codes and name tables for the XML entity decoder.
// No dependencies; every module of the block imports this package.
package xed_pkg;

	// Class of a text byte as seen by the decoder.
	typedef enum logic [1:0] {
		CLS_PLAIN = 2'd0,
		CLS_AMP   = 2'd1,
		CLS_SEMI  = 2'd2
	} xed_cls_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_end;
	} xed_in_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic [1:0] fault;
		logic       final_out;
	} xed_out_t;

	// One classified byte as it travels from the front end to the back end.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_end;
		xed_cls_t   cls;
	} xed_tok_t;

	localparam logic [1:0] FAULT_OK        = 2'd0;
	localparam logic [1:0] FAULT_NO_DIGITS = 2'd1;
	localparam logic [1:0] FAULT_RANGE     = 2'd2;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LX   = 8'h78;
	localparam logic [7:0] CH_UX   = 8'h58;
	localparam logic [7:0] CH_NUL  = 8'h00;

	localparam logic [20:0] CP_LIMIT = 21'h10FFFF;
	localparam logic [20:0] CP_SAT   = 21'h110000;

	// Named entities: amp, lt, gt, quot, apos.
	localparam int NAME_N = 5;
	localparam logic [7:0] NAME_CHR [NAME_N][4] = '{
		'{8'h61, 8'h6D, 8'h70, 8'h00},
		'{8'h6C, 8'h74, 8'h00, 8'h00},
		'{8'h67, 8'h74, 8'h00, 8'h00},
		'{8'h71, 8'h75, 8'h6F, 8'h74},
		'{8'h61, 8'h70, 8'h6F, 8'h73}
	};
	localparam logic [2:0] NAME_LEN [NAME_N] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd4};
	localparam logic [7:0] NAME_OUT [NAME_N] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

	function automatic xed_cls_t byte_class(input logic [7:0] b);
		xed_cls_t c;
		case (b)
			CH_AMP:  c = CLS_AMP;
			CH_SEMI: c = CLS_SEMI;
			default: c = CLS_PLAIN;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/xed_front.sv =====
// Front end of the XML entity decoder: input register and byte classifier.
// Depends on xed_pkg; feeds xed_queue.
module xed_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  xed_pkg::xed_in_t   in_item,
	output logic               push_valid,
	output xed_pkg::xed_tok_t  push_tok,
	input  logic               push_ready
);
	import xed_pkg::*;

	logic     valid_s1;
	xed_tok_t tok_s1;

	// The stage takes a new byte whenever it is empty or its byte moves on.
	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_tok   = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tok_s1.text_byte <= in_item.text_byte;
			tok_s1.text_end  <= in_item.text_end;
			tok_s1.cls       <= byte_class(in_item.text_byte);
		end
	end

endmodule

// ===== hdl/xed_queue.sv =====
// Small FIFO of classified bytes between front and back end.
// Depends on xed_pkg for the token type.
module xed_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  xed_pkg::xed_tok_t  push_tok,
	output logic               push_ready,
	output logic               pop_valid,
	output xed_pkg::xed_tok_t  pop_tok,
	input  logic               pop
);
	import xed_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	xed_tok_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_tok    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/xed_back.sv =====
// Back end of the XML entity decoder: reference buffer, incremental name and
// number matching, rescan on overflow, and the byte emission sequencer.
// Depends on xed_pkg; takes tokens from xed_queue.
module xed_back #(
	parameter int unsigned WINDOW = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  xed_pkg::xed_tok_t  q_tok,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output xed_pkg::xed_out_t  out_item
);
	import xed_pkg::*;

	localparam int unsigned DEPTH = WINDOW - 1;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(WINDOW);

	typedef enum logic [4:0] {
		ST_RUN   = 5'b00001,
		ST_LAMP  = 5'b00010,
		ST_LBODY = 5'b00100,
		ST_LSEMI = 5'b01000,
		ST_UTF   = 5'b10000
	} state_t;

	function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
		logic [4:0] r;
		r = '0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, c[3:0]};
		end else if (hex && (c inside {[8'h61:8'h66]})) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (hex && (c inside {[8'h41:8'h46]})) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic [2:0] utf_len(input logic [20:0] cp);
		logic [2:0] n;
		if (cp < 21'h80) begin
			n = 3'd1;
		end else if (cp < 21'h800) begin
			n = 3'd2;
		end else if (cp < 21'h10000) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	function automatic logic [7:0] utf_byte(input logic [20:0] cp, input logic [2:0] n,
			input logic [1:0] i);
		logic [1:0] k;
		logic [7:0] r;
		k = 2'(n - 3'd1 - {1'b0, i});
		if (i == 2'd0) begin
			case (n)
				3'd1:    r = {1'b0, cp[6:0]};
				3'd2:    r = {3'b110, cp[10:6]};
				3'd3:    r = {4'b1110, cp[15:12]};
				default: r = {5'b11110, cp[20:18]};
			endcase
		end else begin
			case (k)
				2'd0:    r = {2'b10, cp[5:0]};
				2'd1:    r = {2'b10, cp[11:6]};
				default: r = {2'b10, cp[17:12]};
			endcase
		end
		return r;
	endfunction

	state_t              state_q, state_d;
	logic                in_ent_q, in_ent_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [7:0]          pend_q [DEPTH];
	logic [NAME_N-1:0]   m_q, m_d;
	logic                hash_q, hash_d;
	logic                hex_q, hex_d;
	logic                stop_q, stop_d;
	logic                ndig_q, ndig_d;
	logic [20:0]         val_q, val_d;
	logic                rs_act_q, rs_act_d;
	logic [CW-1:0]       rs_idx_q, rs_idx_d;
	logic [CW-1:0]       rs_n_q, rs_n_d;
	logic [7:0]          held_q, held_d;
	logic                held_end_q, held_end_d;
	logic                semi_q, semi_d;
	logic                fin_q, fin_d;
	logic [AW-1:0]       lit_idx_q, lit_idx_d;
	logic [2:0]          utf_n_q, utf_n_d;
	logic [1:0]          utf_i_q, utf_i_d;
	logic                out_valid_q;
	xed_out_t            out_item_q;

	logic                can_emit;
	logic                emit;
	xed_out_t            emit_item;
	logic                done;
	logic                wr_en;
	logic [AW-1:0]       rd_addr;
	logic [7:0]          rd_byte;
	logic                rs_last;
	logic                src_avail;
	logic [7:0]          src_byte;
	xed_cls_t            src_cls;
	logic                src_end;
	logic                take;
	logic                name_hit;
	logic [7:0]          name_out;
	logic [NAME_N-1:0]   m_upd;
	logic [4:0]          dg;
	logic [24:0]         prod;
	logic [24:0]         acc;
	logic [20:0]         val_nx;
	logic                is_x;
	logic                lit_last;
	logic                utf_last;

	assign can_emit  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign rs_last   = (rs_idx_q == rs_n_q);
	assign rd_addr   = (state_q == ST_LBODY) ? lit_idx_q : rs_idx_q[AW-1:0];
	assign rd_byte   = pend_q[rd_addr];

	assign src_avail = rs_act_q || q_valid;
	assign src_byte  = rs_act_q ? (rs_last ? held_q : rd_byte) : q_tok.text_byte;
	assign src_cls   = rs_act_q ? byte_class(src_byte) : q_tok.cls;
	assign src_end   = rs_act_q ? (held_end_q && rs_last) : q_tok.text_end;
	assign take      = (state_q == ST_RUN) && src_avail && can_emit;
	assign q_pop     = take && !rs_act_q;

	assign lit_last  = ((CW'(lit_idx_q) + CW'(1)) == cnt_q);
	assign utf_last  = (({1'b0, utf_i_q} + 3'd1) == utf_n_q);

	// Name matching and numeric parsing advance with each buffered byte.
	always_comb begin
		name_hit = 1'b0;
		name_out = CH_NUL;
		for (int k = 0; k < NAME_N; k++) begin
			m_upd[k] = m_q[k] && (int'(cnt_q) < int'(NAME_LEN[k])) &&
				(src_byte == NAME_CHR[k][cnt_q[1:0]]);
			if (m_q[k] && (int'(cnt_q) == int'(NAME_LEN[k]))) begin
				name_hit = 1'b1;
				name_out = NAME_OUT[k];
			end
		end
		dg     = digit_of(src_byte, hex_q);
		prod   = hex_q ? {val_q, 4'b0000} : ({1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0});
		acc    = prod + 25'(dg[3:0]);
		val_nx = (acc > 25'(CP_LIMIT)) ? CP_SAT : acc[20:0];
		is_x   = (src_byte == CH_LX) || (src_byte == CH_UX);
	end

	always_comb begin
		state_d    = state_q;
		in_ent_d   = in_ent_q;
		cnt_d      = cnt_q;
		m_d        = m_q;
		hash_d     = hash_q;
		hex_d      = hex_q;
		stop_d     = stop_q;
		ndig_d     = ndig_q;
		val_d      = val_q;
		rs_act_d   = rs_act_q;
		rs_idx_d   = rs_idx_q;
		rs_n_d     = rs_n_q;
		held_d     = held_q;
		held_end_d = held_end_q;
		semi_d     = semi_q;
		fin_d      = fin_q;
		lit_idx_d  = lit_idx_q;
		utf_n_d    = utf_n_q;
		utf_i_d    = utf_i_q;
		emit       = 1'b0;
		emit_item  = '{plain_byte: CH_NUL, fault: FAULT_OK, final_out: 1'b0};
		done       = 1'b0;
		wr_en      = 1'b0;

		case (state_q)
			ST_RUN: begin
				if (take) begin
					if (rs_act_q) begin
						if (rs_last) begin
							rs_act_d = 1'b0;
						end else begin
							rs_idx_d = rs_idx_q + 1'b1;
						end
					end
					if (!in_ent_q) begin
						if (src_cls == CLS_AMP) begin
							in_ent_d = 1'b1;
							cnt_d    = '0;
							m_d      = '1;
							hash_d   = 1'b0;
							hex_d    = 1'b0;
							stop_d   = 1'b0;
							ndig_d   = 1'b0;
							val_d    = '0;
							if (src_end) begin
								state_d = ST_LAMP;
								semi_d  = 1'b0;
								fin_d   = 1'b1;
							end
						end else begin
							emit      = 1'b1;
							emit_item = '{plain_byte: src_byte, fault: FAULT_OK,
								final_out: src_end};
						end
					end else if (src_cls == CLS_SEMI) begin
						in_ent_d = 1'b0;
						if (name_hit) begin
							emit      = 1'b1;
							emit_item = '{plain_byte: name_out, fault: FAULT_OK,
								final_out: src_end};
							cnt_d     = '0;
						end else if (hash_q && (cnt_q != '0)) begin
							cnt_d = '0;
							if (!ndig_q) begin
								emit      = 1'b1;
								emit_item = '{plain_byte: CH_NUL, fault: FAULT_NO_DIGITS,
									final_out: src_end};
							end else if (val_q > CP_LIMIT) begin
								emit      = 1'b1;
								emit_item = '{plain_byte: CH_NUL, fault: FAULT_RANGE,
									final_out: src_end};
							end else begin
								state_d = ST_UTF;
								utf_n_d = utf_len(val_q);
								utf_i_d = '0;
								fin_d   = src_end;
							end
						end else begin
							state_d = ST_LAMP;
							semi_d  = 1'b1;
							fin_d   = src_end;
						end
					end else if (cnt_q != CW'(DEPTH)) begin
						wr_en = 1'b1;
						cnt_d = cnt_q + 1'b1;
						m_d   = m_upd;
						if (cnt_q == '0) begin
							hash_d = (src_byte == CH_HASH);
						end else if (hash_q && !stop_q) begin
							if ((cnt_q == CW'(1)) && is_x) begin
								hex_d = 1'b1;
							end else if (dg[4]) begin
								val_d  = val_nx;
								ndig_d = 1'b1;
							end else begin
								stop_d = 1'b1;
							end
						end
						if (src_end) begin
							state_d = ST_LAMP;
							semi_d  = 1'b0;
							fin_d   = 1'b1;
						end
					end else begin
						emit       = 1'b1;
						emit_item  = '{plain_byte: CH_AMP, fault: FAULT_OK, final_out: 1'b0};
						rs_act_d   = 1'b1;
						rs_idx_d   = '0;
						rs_n_d     = cnt_q;
						held_d     = src_byte;
						held_end_d = src_end;
						in_ent_d   = 1'b0;
						cnt_d      = '0;
					end
				end
			end
			ST_LAMP: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_item = '{plain_byte: CH_AMP, fault: FAULT_OK,
						final_out: fin_q && !semi_q && (cnt_q == '0)};
					if (cnt_q != '0) begin
						state_d   = ST_LBODY;
						lit_idx_d = '0;
					end else if (semi_q) begin
						state_d = ST_LSEMI;
					end else begin
						done = 1'b1;
					end
				end
			end
			ST_LBODY: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_item = '{plain_byte: rd_byte, fault: FAULT_OK,
						final_out: fin_q && !semi_q && lit_last};
					if (!lit_last) begin
						lit_idx_d = lit_idx_q + 1'b1;
					end else if (semi_q) begin
						state_d = ST_LSEMI;
					end else begin
						done = 1'b1;
					end
				end
			end
			ST_LSEMI: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_item = '{plain_byte: CH_SEMI, fault: FAULT_OK, final_out: fin_q};
					done      = 1'b1;
				end
			end
			ST_UTF: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_item = '{plain_byte: utf_byte(val_q, utf_n_q, utf_i_q),
						fault: FAULT_OK, final_out: fin_q && utf_last};
					if (utf_last) begin
						done = 1'b1;
					end else begin
						utf_i_d = utf_i_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase

		if (done) begin
			state_d  = ST_RUN;
			in_ent_d = 1'b0;
			cnt_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			in_ent_q    <= 1'b0;
			cnt_q       <= '0;
			m_q         <= '0;
			hash_q      <= 1'b0;
			hex_q       <= 1'b0;
			stop_q      <= 1'b0;
			ndig_q      <= 1'b0;
			rs_act_q    <= 1'b0;
			rs_idx_q    <= '0;
			rs_n_q      <= '0;
			held_end_q  <= 1'b0;
			semi_q      <= 1'b0;
			fin_q       <= 1'b0;
			lit_idx_q   <= '0;
			utf_n_q     <= 3'd1;
			utf_i_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			in_ent_q   <= in_ent_d;
			cnt_q      <= cnt_d;
			m_q        <= m_d;
			hash_q     <= hash_d;
			hex_q      <= hex_d;
			stop_q     <= stop_d;
			ndig_q     <= ndig_d;
			rs_act_q   <= rs_act_d;
			rs_idx_q   <= rs_idx_d;
			rs_n_q     <= rs_n_d;
			held_end_q <= held_end_d;
			semi_q     <= semi_d;
			fin_q      <= fin_d;
			lit_idx_q  <= lit_idx_d;
			utf_n_q    <= utf_n_d;
			utf_i_q    <= utf_i_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q  <= val_d;
		held_q <= held_d;
		if (wr_en) begin
			pend_q[cnt_q[AW-1:0]] <= src_byte;
		end
		if (emit) begin
			out_item_q <= emit_item;
		end
	end

endmodule

// ===== hdl/xml_entity_decoder_core.sv =====
// Top level of the XML character entity decoder with UTF-8 output.
// Depends on xed_pkg, xed_front, xed_queue and xed_back.
//
// The decoder takes escaped text one byte per transfer and returns decoded
// bytes one per transfer. Bytes other than '&' pass straight through. After
// an '&' up to WINDOW-1 bytes are held until ';' arrives. The names amp, lt,
// gt, quot and apos each become one character; "#digits" and "#xdigits"
// become the code point in one to four UTF-8 bytes, or one error result with
// plain_byte zero when there are no digits or the value is above 0x10FFFF.
// Any other name comes back literally with its '&' and ';'. When the window
// fills before ';', the '&' is returned and the held bytes plus the new one
// are scanned again as fresh text. When text_end arrives with a reference
// still open, the '&' and the held bytes come back literally, and final_out
// marks the last result of that input transfer. In the common case, while
// out_ready stays high, one byte is accepted and one result is produced
// every clock cycle. The back end has a single output register, so a
// transfer that completes a reference through the output sequencer takes
// the ';' and then emits its results one at a time, while a named entity
// or an error result is emitted as the ';' is taken. A text that ends
// inside a reference likewise takes its last byte and then emits its
// results one at a time. A window overflow emits the '&' and then rescans
// the held bytes and the new one as fresh text. A front register and a
// queue of QUEUE_DEPTH entries keep taking input while the back end works
// through such a burst. The path from an input transfer to its first
// result runs through the front register, the queue and the back end's
// output register.
module xml_entity_decoder_core #(
	parameter int unsigned WINDOW      = 10,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  xed_pkg::xed_in_t   in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output xed_pkg::xed_out_t  out_item
);
	import xed_pkg::*;

	// Classified bytes from the front register into the queue.
	logic     push_valid;
	logic     push_ready;
	xed_tok_t push_tok;

	// Queue head as seen by the back end.
	logic     pop_valid;
	logic     pop;
	xed_tok_t pop_tok;

	xed_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_tok   (push_tok),
		.push_ready (push_ready)
	);

	xed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_tok   (push_tok),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_tok    (pop_tok),
		.pop        (pop)
	);

	// The back end owns the reference buffer and the output register.
	xed_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_tok     (pop_tok),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== hdl/xed_checker.sv =====
// Port-level checker for the XML entity decoder and its bind to the top level.
// Depends on xed_pkg and the assertion macro header.
`include "xml_entity_decoder_core_assert.svh"

module xed_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input xed_pkg::xed_in_t   in_item,
	input logic               out_valid,
	input logic               out_ready,
	input xed_pkg::xed_out_t  out_item
);
	import xed_pkg::*;

	// Texts whose end has been transferred in but whose final result is still owed.
	logic [7:0] ends_owed_q;
	logic       end_in;
	logic       final_out_xfer;

	assign end_in         = in_valid && in_ready && in_item.text_end;
	assign final_out_xfer = out_valid && out_ready && out_item.final_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ends_owed_q <= '0;
		end else if (end_in && !final_out_xfer) begin
			ends_owed_q <= ends_owed_q + 1'b1;
		end else if (final_out_xfer && !end_in) begin
			ends_owed_q <= ends_owed_q - 1'b1;
		end
	end

	`XED_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item), "result changed or dropped while stalled")
	`XED_ASSERT_ALWAYS(a_fault_byte, clk, arst_n, !out_valid || out_item.fault == FAULT_OK || out_item.plain_byte == CH_NUL, "error result carries a nonzero byte")
	`XED_ASSERT_IMPLY(a_final_owed, clk, arst_n, out_valid && out_item.final_out, ends_owed_q != 8'd0, "final result without an open text end")

endmodule

bind xml_entity_decoder_core xed_checker u_xed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
